### rtl/pncr_pkg.sv
`timescale 1ns / 1ps

package pncr_pkg;

  localparam int DEF_PALETTE_DEPTH = 256;
  localparam int DEF_CACHE_SETS    = 64;

  localparam int LANES       = 16;
  localparam int LANE_W      = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int SIZE_W      = 9;
  localparam int DIST_W      = 18;

  localparam logic [1:0] OP_PIXEL    = 2'd0;
  localparam logic [1:0] OP_PAL_WR   = 2'd1;
  localparam logic [1:0] OP_ALPHA_WR = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       start_of_image;
    logic [7:0] table_index;
    logic [7:0] table_alpha_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic [7:0] chosen_index;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_PIXEL    = 2'd0,
    CMD_PAL_WR   = 2'd1,
    CMD_ALPHA_WR = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       sof;
    logic [7:0] table_index;
    logic [7:0] table_alpha_value;
  } cmd_t;

  function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d * d);
  endfunction

endpackage

### rtl/pncr_front.sv
`timescale 1ns / 1ps

module pncr_front #(
  parameter int PALETTE_DEPTH = pncr_pkg::DEF_PALETTE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  pncr_pkg::in_item_t request,
  output pncr_pkg::cmd_t    head,
  output logic              head_empty,
  input  logic              head_pop
);
  import pncr_pkg::*;

  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  cmd_t              cmd;
  logic              keep;
  logic              enq;

  // Classify: drop unused opcodes and palette writes past the store.
  always_comb begin
    cmd.red               = request.red;
    cmd.green             = request.green;
    cmd.blue              = request.blue;
    cmd.alpha             = request.alpha;
    cmd.sof               = request.start_of_image;
    cmd.table_index       = request.table_index;
    cmd.table_alpha_value = request.table_alpha_value;
    cmd.kind              = CMD_PIXEL;
    keep                  = 1'b0;
    unique case (request.opcode)
      OP_PIXEL: begin
        cmd.kind = CMD_PIXEL;
        keep     = 1'b1;
      end
      OP_PAL_WR: begin
        cmd.kind = CMD_PAL_WR;
        keep     = ({1'b0, request.table_index} < SIZE_W'(PALETTE_DEPTH));
      end
      OP_ALPHA_WR: begin
        cmd.kind = CMD_ALPHA_WR;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_empty = (count == '0);
  assign head       = queue[rd_ptr];
  assign enq        = push && !full && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) wr_ptr <= wr_ptr + 1'b1;
      if (head_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W + 1)'(enq) - (QPTR_W + 1)'(head_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) queue[wr_ptr] <= cmd;
  end

endmodule

### rtl/pncr_back.sv
`timescale 1ns / 1ps

module pncr_back #(
  parameter int PALETTE_DEPTH = pncr_pkg::DEF_PALETTE_DEPTH,
  parameter int CACHE_SETS    = pncr_pkg::DEF_CACHE_SETS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [pncr_pkg::SIZE_W-1:0] cfg_data,
  input  pncr_pkg::cmd_t              head,
  input  logic                        head_empty,
  output logic                        head_pop,
  output logic                        empty,
  input  logic                        pop,
  output pncr_pkg::out_item_t         result
);
  import pncr_pkg::*;

  localparam int ROWS  = (PALETTE_DEPTH + LANES - 1) / LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SET_W = (CACHE_SETS > 1) ? $clog2(CACHE_SETS) : 1;

  typedef logic [SET_W-1:0] set_tbl_t [256];

  function automatic set_tbl_t build_set_tbl();
    set_tbl_t t;
    for (int v = 0; v < 256; v++) t[v] = SET_W'(v % CACHE_SETS);
    return t;
  endfunction

  localparam set_tbl_t SET_TBL = build_set_tbl();

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_SEARCH = 4'b0100,
    S_FETCH  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [SIZE_W-1:0] palette_size;
  logic [SIZE_W-1:0] n_eff;
  logic [ROW_W-1:0]  last_row;

  cmd_t             px;
  logic [SET_W-1:0] px_set;
  logic [SET_W-1:0] head_set;

  logic [CACHE_SETS-1:0] cache_valid;
  logic [31:0]           cache_mem [CACHE_SETS];
  logic [31:0]           cache_q;
  logic                  cache_re, cache_we, clear_all, hit;

  logic [7:0] alpha_mem [256];
  logic [7:0] alpha_q;
  logic       alpha_re, alpha_we;

  logic [23:0]       pal_mem [LANES][ROWS];
  logic [23:0]       bank_q [LANES];
  logic              bank_re, bank_we;
  logic [ROW_W-1:0]  bank_raddr;

  logic [ROW_W-1:0]  issue_row;
  logic              issue_done;
  logic              p1_vld, p2_vld;
  logic [ROW_W-1:0]  p1_row, p2_row;
  logic [DIST_W-1:0] lane_dist [LANES];
  logic              lane_ok [LANES];
  logic [DIST_W-1:0] best_d;
  logic [7:0]        best_idx;

  logic [DIST_W-1:0] td [LANE_W+1][LANES];
  logic [LANE_W-1:0] ti [LANE_W+1][LANES];

  logic      out_valid;
  out_item_t out_item;

  always_comb begin
    if (palette_size == '0) n_eff = SIZE_W'(1);
    else if (palette_size > SIZE_W'(PALETTE_DEPTH)) n_eff = SIZE_W'(PALETTE_DEPTH);
    else n_eff = palette_size;
  end

  assign last_row = ROW_W'((n_eff - 1'b1) >> LANE_W);
  assign head_set = SET_TBL[head.red ^ head.green ^ head.blue];
  assign hit      = cache_valid[px_set] && (cache_q[31:8] == {px.red, px.green, px.blue});

  always_comb begin
    state_next = state;
    head_pop   = 1'b0;
    bank_re    = 1'b0;
    bank_we    = 1'b0;
    bank_raddr = issue_row;
    cache_re   = 1'b0;
    cache_we   = 1'b0;
    alpha_re   = 1'b0;
    alpha_we   = 1'b0;
    clear_all  = cfg_valid;
    unique case (state)
      S_IDLE: begin
        if (!head_empty) begin
          head_pop = 1'b1;
          unique case (head.kind)
            CMD_PAL_WR: begin
              bank_we   = 1'b1;
              clear_all = 1'b1;
            end
            CMD_ALPHA_WR: alpha_we = 1'b1;
            CMD_PIXEL: begin
              cache_re   = 1'b1;
              alpha_re   = 1'b1;
              clear_all  = cfg_valid || head.sof;
              state_next = S_LOOKUP;
            end
            default: ;
          endcase
        end
      end
      S_LOOKUP: begin
        if (hit) begin
          bank_re    = 1'b1;
          bank_raddr = ROW_W'(cache_q[7:0] >> LANE_W);
          state_next = S_FETCH;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!issue_done) begin
          bank_re = 1'b1;
        end else if (!p1_vld && !p2_vld) begin
          // Search drained: record in cache and read back the winner's row.
          cache_we   = 1'b1;
          bank_re    = 1'b1;
          bank_raddr = ROW_W'(best_idx >> LANE_W);
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (!out_valid) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Minimum over the lanes as a balanced tree; ties keep the lower lane.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      td[0][l] = lane_ok[l] ? lane_dist[l] : '1;
      ti[0][l] = LANE_W'(l);
    end
    for (int lv = 0; lv < LANE_W; lv++) begin
      for (int k = 0; k < LANES; k++) begin
        if (k < (LANES >> (lv + 1))) begin
          if (td[lv][2*k+1] < td[lv][2*k]) begin
            td[lv+1][k] = td[lv][2*k+1];
            ti[lv+1][k] = ti[lv][2*k+1];
          end else begin
            td[lv+1][k] = td[lv][2*k];
            ti[lv+1][k] = ti[lv][2*k];
          end
        end else begin
          td[lv+1][k] = '1;
          ti[lv+1][k] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      palette_size <= SIZE_W'(1);
      cache_valid  <= '0;
      out_valid    <= 1'b0;
      issue_done   <= 1'b1;
      p1_vld       <= 1'b0;
      p2_vld       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) palette_size <= cfg_data;
      if (clear_all) cache_valid <= '0;
      else if (cache_we) cache_valid[px_set] <= 1'b1;
      if (pop && out_valid) out_valid <= 1'b0;
      else if (state == S_FETCH) out_valid <= 1'b1;
      if (state == S_LOOKUP) issue_done <= 1'b0;
      else if (state == S_SEARCH && !issue_done && issue_row == last_row) issue_done <= 1'b1;
      p1_vld <= (state == S_SEARCH) && !issue_done;
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && !head_empty && head.kind == CMD_PIXEL) begin
      px     <= head;
      px_set <= head_set;
    end
    if (state == S_LOOKUP) begin
      issue_row <= '0;
      best_d    <= '1;
      best_idx  <= cache_q[7:0];
    end else begin
      if (state == S_SEARCH && !issue_done) issue_row <= issue_row + 1'b1;
      if (p2_vld && td[LANE_W][0] < best_d) begin
        best_d   <= td[LANE_W][0];
        best_idx <= 8'({p2_row, ti[LANE_W][0]});
      end
    end
    p1_row <= issue_row;
    p2_row <= p1_row;
    for (int l = 0; l < LANES; l++) begin
      lane_dist[l] <= DIST_W'(chan_sq(px.red, bank_q[l][23:16]))
                    + DIST_W'(chan_sq(px.green, bank_q[l][15:8]))
                    + DIST_W'(chan_sq(px.blue, bank_q[l][7:0]));
      lane_ok[l] <= (SIZE_W'({p1_row, LANE_W'(l)}) < n_eff);
    end
    if (state == S_FETCH && !out_valid) begin
      out_item.out_red      <= bank_q[best_idx[LANE_W-1:0]][23:16];
      out_item.out_green    <= bank_q[best_idx[LANE_W-1:0]][15:8];
      out_item.out_blue     <= bank_q[best_idx[LANE_W-1:0]][7:0];
      out_item.out_alpha    <= alpha_q;
      out_item.chosen_index <= best_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cache_we) cache_mem[px_set] <= {px.red, px.green, px.blue, best_idx};
    if (cache_re) cache_q <= cache_mem[head_set];
  end

  always_ff @(posedge clk) begin
    if (alpha_we) alpha_mem[head.table_index] <= head.table_alpha_value;
    if (alpha_re) alpha_q <= alpha_mem[head.alpha];
  end

  for (genvar g = 0; g < LANES; g++) begin : g_bank
    always_ff @(posedge clk) begin
      if (bank_we && head.table_index[LANE_W-1:0] == LANE_W'(g))
        pal_mem[g][ROW_W'(head.table_index >> LANE_W)] <= {head.red, head.green, head.blue};
      if (bank_re) bank_q[g] <= pal_mem[g][bank_raddr];
    end
  end

  assign empty  = !out_valid;
  assign result = out_item;

endmodule

### rtl/palette_nearest_color_remap_core.sv
`timescale 1ns / 1ps

// Nearest-palette color remapper. A pixel item that hits in the cache reads
// the cached index's palette row directly; a miss runs the 16-lane distance
// search, which reads one palette row per cycle. Palette and alpha table
// writes are applied as they leave the queue. A two-entry queue decouples
// the input from the engine, and one result register holds the oldest result.
// The cache is cleared by start_of_image on a pixel, by any in-range palette
// write and by a palette_size write; configuration is always ready and must be
// written only while no item is in flight.
module palette_nearest_color_remap_core #(
  parameter int PALETTE_DEPTH = pncr_pkg::DEF_PALETTE_DEPTH,
  parameter int CACHE_SETS    = pncr_pkg::DEF_CACHE_SETS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  pncr_pkg::in_item_t          request,
  output logic                        empty,
  input  logic                        pop,
  output pncr_pkg::out_item_t         result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pncr_pkg::SIZE_W-1:0] cfg_data
);
  import pncr_pkg::*;

  cmd_t head;
  logic head_empty;
  logic head_pop;

  assign cfg_ready = 1'b1;

  pncr_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .head      (head),
    .head_empty(head_empty),
    .head_pop  (head_pop)
  );

  pncr_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .CACHE_SETS   (CACHE_SETS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .head      (head),
    .head_empty(head_empty),
    .head_pop  (head_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> !head_empty) else $error("engine popped an empty queue");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    full |-> !head_empty) else $error("queue full with no head item");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (!head_empty && !head_pop) |=> !head_empty) else $error("queue head lost");

endmodule
